[hw/rtl/alle_pkg.sv]
`timescale 1ns / 1ps

package alle_pkg;

  // Default number of list slots
  localparam int ENTRIES_DEF = 4;

  // Request codes
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_REPLACE = 2'd2;
  localparam logic [1:0] REQ_LOCATE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

endpackage

[hw/rtl/array_linked_list_engine.sv]
`timescale 1ns / 1ps

// Singly linked list of up to ENTRIES 32-bit values kept in a slot array. Each request
// word (insert at tail, remove first match, replace first match, locate first match)
// gives one result word with a status, the slot index touched, the element count and
// an empty flag. An insert fills a free slot, then links it to the tail in ST_LINK.
// Remove, replace and locate walk from the head in ST_WALK, visiting at most ENTRIES
// elements: the list walk follows one link per cycle through the value and link
// memories, whose single read port is the limit. A request that finds the list empty
// goes straight to ST_DONE. A new word is accepted once the previous result has moved
// to the output register; no init sweep is needed after reset.
module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_new_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [1:0]  out_position,
  output logic [2:0]  out_count,
  output logic        out_empty_res
);

  localparam int IW = $clog2(ENTRIES);      // slot index width
  localparam int LW = $clog2(ENTRIES + 1);  // link width, holds the null link
  localparam int CW = $clog2(ENTRIES + 1);  // element count width
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK,
    ST_DONE
  } state_t;

  function automatic logic link_ok(input logic [LW-1:0] lnk);
    return lnk < NULL_LINK;
  endfunction

  // Slot storage: values and next links, one read and one write port each
  logic [31:0]   val_mem [ENTRIES];
  logic [LW-1:0] nxt_mem [ENTRIES];
  logic [31:0]   val_rd_r;
  logic [LW-1:0] nxt_rd_r;

  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic          val_we;
  logic [IW-1:0] val_wa;
  logic [31:0]   val_wd;
  logic          nxt_we;
  logic [IW-1:0] nxt_wa;
  logic [LW-1:0] nxt_wd;

  // Control and list state
  state_t        state_r, state_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   nval_r, nval_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [1:0]    pos_r, pos_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [1:0]    out_pos_r, out_pos_nxt;
  logic [2:0]    out_count_r, out_count_nxt;
  logic          out_empty_r, out_empty_nxt;

  // Helpers
  logic          in_acc;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] cur_idx;
  logic [IW+1:0] cur_ext;
  logic [CW+2:0] cnt_ext;
  logic [LW-1:0] walk_link;
  logic [LW-1:0] steps_inc;
  logic          walk_match;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_position  = out_pos_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;

  assign cur_idx   = cur_r[IW-1:0];
  assign cur_ext   = {2'b00, cur_idx};
  assign cnt_ext   = {3'b000, cnt_r};
  assign steps_inc = steps_r + 1'b1;

  // A link read from an unused slot counts as null
  assign walk_link  = used_r[cur_idx] ? nxt_rd_r : NULL_LINK;
  assign walk_match = used_r[cur_idx] && (val_rd_r == key_r);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Request sequencing and list update
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    nval_nxt       = nval_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    steps_nxt      = steps_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    rd_en          = 1'b0;
    rd_idx         = cur_idx;
    val_we         = 1'b0;
    val_wa         = cur_idx;
    val_wd         = nval_r;
    nxt_we         = 1'b0;
    nxt_wa         = cur_idx;
    nxt_wd         = NULL_LINK;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_req_type;
          key_nxt   = in_value;
          nval_nxt  = in_new_value;
          prev_nxt  = NULL_LINK;
          steps_nxt = '0;
          pos_nxt   = '0;
          if (in_req_type == REQ_INSERT) begin
            if (free_found) begin
              // fill the new slot now, hook it to the tail next cycle
              val_we    = 1'b1;
              val_wa    = free_idx;
              val_wd    = in_value;
              nxt_we    = 1'b1;
              nxt_wa    = free_idx;
              nxt_wd    = NULL_LINK;
              cur_nxt   = LW'(free_idx);
              state_nxt = ST_LINK;
            end else begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_DONE;
            end
          end else begin
            cur_nxt = head_r;
            if (link_ok(head_r)) begin
              rd_en     = 1'b1;
              rd_idx    = head_r[IW-1:0];
              state_nxt = ST_WALK;
            end else begin
              status_nxt = STAT_NOT_FOUND;
              state_nxt  = ST_DONE;
            end
          end
        end
      end

      ST_WALK: begin
        if (walk_match) begin
          status_nxt = STAT_DONE;
          pos_nxt    = cur_ext[1:0];
          state_nxt  = ST_DONE;
          case (req_r)
            REQ_REMOVE: begin
              if (link_ok(prev_r)) begin
                nxt_we = 1'b1;
                nxt_wa = prev_r[IW-1:0];
                nxt_wd = walk_link;
              end else begin
                head_nxt = walk_link;
              end
              if (tail_r == cur_r) begin
                tail_nxt = prev_r;
              end
              used_nxt[cur_idx] = 1'b0;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end
              // list drained
              if (cnt_r <= CW'(1)) begin
                head_nxt = NULL_LINK;
                tail_nxt = NULL_LINK;
              end
            end
            REQ_REPLACE: begin
              val_we = 1'b1;
              val_wa = cur_idx;
              val_wd = nval_r;
            end
            default: begin
            end
          endcase
        end else begin
          // follow the link, bounded by the slot count
          prev_nxt  = cur_r;
          cur_nxt   = walk_link;
          steps_nxt = steps_inc;
          if ((steps_inc < NULL_LINK) && link_ok(walk_link)) begin
            rd_en  = 1'b1;
            rd_idx = walk_link[IW-1:0];
          end else begin
            status_nxt = STAT_NOT_FOUND;
            pos_nxt    = '0;
            state_nxt  = ST_DONE;
          end
        end
      end

      ST_LINK: begin
        if ((cnt_r == '0) || !link_ok(tail_r)) begin
          head_nxt = cur_r;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = tail_r[IW-1:0];
          nxt_wd = cur_r;
        end
        tail_nxt          = cur_r;
        used_nxt[cur_idx] = 1'b1;
        cnt_nxt           = cnt_r + 1'b1;
        status_nxt        = STAT_DONE;
        pos_nxt           = cur_ext[1:0];
        state_nxt         = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = pos_r;
          out_count_nxt  = cnt_ext[2:0];
          out_empty_nxt  = (cnt_r == '0);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (rd_en) begin
      val_rd_r <= val_mem[rd_idx];
      nxt_rd_r <= nxt_mem[rd_idx];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      cnt_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    nval_r       <= nval_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    steps_r      <= steps_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // Element count tracks the number of occupied slots
  a_count_used : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == $countones(used_r))
    else $error("element count differs from occupied slots");

  // An empty list has null head and tail
  a_empty_links : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == NULL_LINK && tail_r == NULL_LINK))
    else $error("empty list with live head or tail");

  // The walk only visits real slots within the step bound
  a_walk_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (cur_r < NULL_LINK && steps_r < NULL_LINK))
    else $error("list walk out of bounds");

endmodule

[test/alle_list_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the list engine, keeps its own copy of the slot
// array and checks every result word against the oldest expected one.
module alle_list_checker
  import alle_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_new_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [1:0]         out_position,
  input  logic [2:0]         out_count,
  input  logic               out_empty_res,
  output int                 mismatch_count,
  output int                 results_pending
);

  localparam logic [2:0] NIL = 3'(ENTRIES);

  typedef struct {
    logic [1:0] status;
    logic [1:0] position;
    logic [2:0] count;
    logic       empty;
  } list_result_t;

  // Shadow of the list storage
  logic [31:0] slot_val  [ENTRIES];
  logic [2:0]  slot_link [ENTRIES];
  logic        slot_busy [ENTRIES];
  logic [2:0]  head_link;
  logic [2:0]  tail_link;
  logic [2:0]  live_count;

  list_result_t pending_results[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_list();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      slot_val[i]  = '0;
      slot_link[i] = NIL;
      slot_busy[i] = 1'b0;
    end
    head_link  = NIL;
    tail_link  = NIL;
    live_count = '0;
  endtask

  // Apply one request to the shadow list and return the result word it gives
  function automatic list_result_t list_apply(input logic [1:0] req, input logic [31:0] key,
                                              input logic [31:0] repl);
    list_result_t r;
    logic [2:0]   cur;
    logic [2:0]   prev;
    logic [2:0]   hit;
    logic [2:0]   nxt;
    logic         found;
    int           i;
    int           steps;
    r.status   = STAT_DONE;
    r.position = '0;
    found      = 1'b0;
    hit        = '0;
    prev       = NIL;
    if (req == REQ_INSERT) begin
      // lowest free slot, linked after the tail
      for (i = 0; i < ENTRIES; i++) begin
        if (!found && !slot_busy[i]) begin
          hit   = 3'(i);
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = STAT_FULL;
      end else begin
        slot_val[hit]  = key;
        slot_link[hit] = NIL;
        slot_busy[hit] = 1'b1;
        if (live_count == 0 || tail_link >= NIL) head_link = hit;
        else slot_link[tail_link] = hit;
        tail_link  = hit;
        live_count = live_count + 3'd1;
        r.position = hit[1:0];
      end
    end else begin
      // bounded walk for the first match in list order
      cur   = head_link;
      steps = 0;
      while (steps < ENTRIES && cur < NIL && !found) begin
        if (slot_busy[cur] && slot_val[cur] == key) begin
          found = 1'b1;
          hit   = cur;
        end else begin
          prev = cur;
          cur  = slot_link[cur];
          steps++;
        end
      end
      if (!found) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        r.position = hit[1:0];
        if (req == REQ_REMOVE) begin
          nxt = slot_link[hit];
          if (prev < NIL) slot_link[prev] = nxt;
          else head_link = nxt;
          if (tail_link == hit) tail_link = prev;
          slot_busy[hit] = 1'b0;
          slot_link[hit] = NIL;
          if (live_count > 0) live_count = live_count - 3'd1;
          if (live_count == 0) begin
            head_link = NIL;
            tail_link = NIL;
          end
        end else if (req == REQ_REPLACE) begin
          slot_val[hit] = repl;
        end
      end
    end
    r.count = live_count;
    r.empty = (live_count == 0);
    return r;
  endfunction

  // Predict on each accepted request word, compare on each accepted result word
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      clear_list();
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready)
        pending_results.push_back(list_apply(in_req_type, in_value, in_new_value));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word with none expected (status %0d pos %0d)",
                                    out_status, out_position));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      out_position, want.position));
          if (out_count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", out_count, want.count));
          if (out_empty_res !== want.empty)
            report_mismatch($sformatf("empty got %0d want %0d", out_empty_res, want.empty));
        end
      end
    end
    results_pending <= pending_results.size();
  end

endmodule

[test/tb_array_linked_list_engine.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the array linked list engine; checking lives in
// alle_list_checker.
module tb_array_linked_list_engine;
  import alle_pkg::*;

  localparam int RANDOM_WORDS = 1330;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_req_type;
  logic signed [31:0] in_value;
  logic signed [31:0] in_new_value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic [1:0]         out_position;
  logic [2:0]         out_count;
  logic               out_empty_res;

  int   mismatch_count;
  int   results_pending;
  int   cycle_count;
  logic steady;   // when set, neither side idles

  // Small key pool so matches and duplicates are common
  logic [31:0] key_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0000_0005, 32'h5A5A_A5A5, 32'hA5A5_5A5A};

  array_linked_list_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  alle_list_checker list_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_position   (out_position),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall before taking each word
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one request word after a random gap; returns at the accepting edge
  task automatic send_word(input logic [1:0] req, input logic [31:0] val,
                           input logic [31:0] nval);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_value     <= val;
    in_new_value <= nval;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Mix leans toward inserts or removes depending on the phase
  function automatic logic [1:0] pick_req(input bit fill_phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (fill_phase ? 50 : 25)) return REQ_INSERT;
    if (roll < (fill_phase ? 65 : 60)) return REQ_REMOVE;
    if (roll < 80) return REQ_REPLACE;
    return REQ_LOCATE;
  endfunction

  initial begin
    logic [1:0] req;
    int         i;
    steady       = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req_type  <= REQ_INSERT;
    in_value     <= '0;
    in_new_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, extremes, full store, duplicates, head/middle/tail removal
    send_word(REQ_LOCATE,  32'h0000_0005, $urandom());
    send_word(REQ_REMOVE,  32'h0000_0005, $urandom());
    send_word(REQ_REPLACE, 32'h0000_0005, 32'h7FFF_FFFF);
    send_word(REQ_INSERT,  32'h7FFF_FFFF, $urandom());
    send_word(REQ_INSERT,  32'h8000_0000, $urandom());
    send_word(REQ_INSERT,  32'h0000_0000, $urandom());
    send_word(REQ_INSERT,  32'hFFFF_FFFF, $urandom());
    send_word(REQ_INSERT,  32'h0000_0001, $urandom());   // store full
    send_word(REQ_LOCATE,  32'hFFFF_FFFF, $urandom());   // tail
    send_word(REQ_REPLACE, 32'h8000_0000, 32'h7FFF_FFFF); // makes a duplicate
    send_word(REQ_LOCATE,  32'h7FFF_FFFF, $urandom());   // first of the pair
    send_word(REQ_REMOVE,  32'h7FFF_FFFF, $urandom());   // head
    send_word(REQ_REMOVE,  32'hFFFF_FFFF, $urandom());   // tail moves back
    send_word(REQ_INSERT,  32'h0000_0007, $urandom());
    send_word(REQ_INSERT,  32'h0000_0007, $urandom());
    send_word(REQ_REMOVE,  32'h0000_0007, $urandom());   // middle, first in list order
    send_word(REQ_LOCATE,  32'h0000_0007, $urandom());
    send_word(REQ_REPLACE, 32'h0000_0000, 32'h8000_0000);
    send_word(REQ_REMOVE,  32'h8000_0000, $urandom());
    send_word(REQ_REMOVE,  32'h7FFF_FFFF, $urandom());
    send_word(REQ_REMOVE,  32'h0000_0007, $urandom());   // last element
    send_word(REQ_LOCATE,  32'h0000_0001, $urandom());
    send_word(REQ_INSERT,  32'h0000_0001, $urandom());   // refill after empty

    // Random: phases alternate between filling and draining, with idle-free stretches
    for (i = 0; i < RANDOM_WORDS; i++) begin
      steady = ((i % 300) >= 240);
      req = pick_req((i / 100) % 2 == 0);
      send_word(req, pick_key(),
                ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 7)] : $urandom());
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
